// ===== sv/tket_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tket_pkg: shared types and constants of the elite tracker
// Item layouts, stored entry layout, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package tket_pkg;

    localparam int unsigned LIST_DEPTH_DEFAULT = 8;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_NEW_GEN  = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] fitness;
        logic [15:0]        payload_tag;
        logic [15:0]        food_amount;
        logic               has_payload;
        logic [2:0]         read_slot;
    } in_item_t;

    typedef struct packed {
        logic               inserted;
        logic [2:0]         insert_rank;
        logic               evicted_valid;
        logic [15:0]        evicted_tag;
        logic               entry_valid;
        logic signed [31:0] entry_fitness;
        logic [15:0]        entry_food;
        logic [15:0]        entry_tag;
        logic [3:0]         list_count;
        logic signed [31:0] best_fitness;
        logic [31:0]        generation_number;
        logic [31:0]        evaluated_count;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] fitness;
        logic [15:0]        food;
        logic [15:0]        tag;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EVICT_RD,
        S_EVICT_CAP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_READ_RD,
        S_READ_CAP,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== sv/tket_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tket_store: ranked entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tket_store #(
    parameter int unsigned LIST_DEPTH = tket_pkg::LIST_DEPTH_DEFAULT,
    parameter int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire                 clk,
    input  tket_pkg::mem_ctl_t  ctl,
    input  wire [AW-1:0]        rd_addr,
    input  wire [AW-1:0]        wr_addr,
    input  tket_pkg::entry_t    wr_data,
    output tket_pkg::entry_t    rd_data
);

    tket_pkg::entry_t mem [LIST_DEPTH];
    tket_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/tket_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tket_ctrl: sequencer and counters of the elite tracker
// Scans the ranks one at a time with a single comparator, then moves the
// lower entries down one slot per step through the shared memory port.
// ----------------------------------------------------------------------------
module tket_ctrl #(
    parameter int unsigned LIST_DEPTH = tket_pkg::LIST_DEPTH_DEFAULT,
    parameter int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  tket_pkg::in_item_t  req,
    output logic                res_valid,
    input  wire                 res_take,
    output tket_pkg::out_item_t res,
    output tket_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]       mem_rd_addr,
    output logic [AW-1:0]       mem_wr_addr,
    output tket_pkg::entry_t    mem_wr_data,
    input  tket_pkg::entry_t    mem_rd_data
);

    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned SW = (CW > 3) ? CW : 3;

    tket_pkg::state_t state_reg, state_next;

    tket_pkg::in_item_t item_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      j_reg;
    logic [31:0]        gen_reg;
    logic [31:0]        eval_reg;
    logic signed [31:0] best_reg;

    logic               inserted_reg;
    logic [2:0]         rank_reg;
    logic               evicted_valid_reg;
    logic [15:0]        evicted_tag_reg;
    logic               entry_valid_reg;
    tket_pkg::entry_t   entry_reg;

    logic          accept;
    logic          full;
    logic [CW-1:0] top;
    logic [CW-1:0] j_minus1;
    logic          idx_end;
    logic          idx_open;
    logic          beats;
    logic          slot_ok;

    assign accept   = req_valid && !req_stall;
    assign full     = (count_reg == CW'(LIST_DEPTH));
    assign top      = full ? CW'(LIST_DEPTH - 1) : count_reg;
    assign j_minus1 = j_reg - CW'(1);
    assign idx_end  = (idx_reg == CW'(LIST_DEPTH));
    assign idx_open = (idx_reg >= count_reg);
    assign beats    = ($signed(item_reg.fitness) > $signed(mem_rd_data.fitness));
    assign slot_ok  = (SW'(item_reg.read_slot) < SW'(count_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tket_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = tket_pkg::S_DISPATCH;
                end
            end
            tket_pkg::S_DISPATCH:
            begin
                case (item_reg.operation)
                    tket_pkg::OP_REGISTER:
                        state_next = item_reg.has_payload ? tket_pkg::S_SCAN_RD
                                                          : tket_pkg::S_DONE;
                    tket_pkg::OP_READ:
                        state_next = slot_ok ? tket_pkg::S_READ_RD : tket_pkg::S_DONE;
                    default:
                        state_next = tket_pkg::S_DONE;
                endcase
            end
            tket_pkg::S_SCAN_RD:
            begin
                if (idx_end)
                begin
                    state_next = tket_pkg::S_DONE;
                end
                else if (idx_open)
                begin
                    state_next = tket_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = tket_pkg::S_SCAN_CMP;
                end
            end
            tket_pkg::S_SCAN_CMP:
            begin
                if (beats)
                begin
                    state_next = full ? tket_pkg::S_EVICT_RD : tket_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = tket_pkg::S_SCAN_RD;
                end
            end
            tket_pkg::S_EVICT_RD:  state_next = tket_pkg::S_EVICT_CAP;
            tket_pkg::S_EVICT_CAP: state_next = tket_pkg::S_SHIFT_RD;
            tket_pkg::S_SHIFT_RD:
            begin
                state_next = (j_reg > pos_reg) ? tket_pkg::S_SHIFT_WR
                                               : tket_pkg::S_WRITE;
            end
            tket_pkg::S_SHIFT_WR:  state_next = tket_pkg::S_SHIFT_RD;
            tket_pkg::S_WRITE:     state_next = tket_pkg::S_DONE;
            tket_pkg::S_READ_RD:   state_next = tket_pkg::S_READ_CAP;
            tket_pkg::S_READ_CAP:  state_next = tket_pkg::S_DONE;
            tket_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = tket_pkg::S_IDLE;
                end
            end
            default: state_next = tket_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake and memory port.
    always_comb
    begin
        req_stall     = 1'b1;
        res_valid     = 1'b0;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        mem_rd_addr   = idx_reg[AW-1:0];
        mem_wr_addr   = pos_reg[AW-1:0];
        mem_wr_data   = mem_rd_data;
        unique case (state_reg)
            tket_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
            end
            tket_pkg::S_SCAN_RD:
            begin
                mem_ctl.rd_en = 1'b1;
            end
            tket_pkg::S_EVICT_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = AW'(LIST_DEPTH - 1);
            end
            tket_pkg::S_SHIFT_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = j_minus1[AW-1:0];
            end
            tket_pkg::S_SHIFT_WR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = j_reg[AW-1:0];
            end
            tket_pkg::S_WRITE:
            begin
                mem_ctl.wr_en       = 1'b1;
                mem_wr_data.fitness = item_reg.fitness;
                mem_wr_data.food    = item_reg.food_amount;
                mem_wr_data.tag     = item_reg.payload_tag;
            end
            tket_pkg::S_READ_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = AW'(item_reg.read_slot);
            end
            tket_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.inserted          = inserted_reg;
        res.insert_rank       = rank_reg;
        res.evicted_valid     = evicted_valid_reg;
        res.evicted_tag       = evicted_tag_reg;
        res.entry_valid       = entry_valid_reg;
        res.entry_fitness     = entry_reg.fitness;
        res.entry_food        = entry_reg.food;
        res.entry_tag         = entry_reg.tag;
        res.list_count        = 4'(count_reg);
        res.best_fitness      = best_reg;
        res.generation_number = gen_reg;
        res.evaluated_count   = eval_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tket_pkg::S_IDLE;
            count_reg         <= '0;
            idx_reg           <= '0;
            pos_reg           <= '0;
            j_reg             <= '0;
            gen_reg           <= 32'd1;
            eval_reg          <= '0;
            best_reg          <= '0;
            inserted_reg      <= 1'b0;
            rank_reg          <= '0;
            evicted_valid_reg <= 1'b0;
            entry_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                inserted_reg      <= 1'b0;
                rank_reg          <= '0;
                evicted_valid_reg <= 1'b0;
                entry_valid_reg   <= 1'b0;
            end
            unique case (state_reg)
                tket_pkg::S_DISPATCH:
                begin
                    idx_reg <= '0;
                    if (item_reg.operation == tket_pkg::OP_NEW_GEN)
                    begin
                        gen_reg  <= gen_reg + 32'd1;
                        eval_reg <= '0;
                    end
                end
                tket_pkg::S_SCAN_RD:
                begin
                    if (idx_end)
                    begin
                        // Full list and nothing beaten: only the count moves.
                        eval_reg <= eval_reg + 32'd1;
                    end
                    else if (idx_open)
                    begin
                        pos_reg <= idx_reg;
                        j_reg   <= top;
                    end
                end
                tket_pkg::S_SCAN_CMP:
                begin
                    if (beats)
                    begin
                        pos_reg <= idx_reg;
                        j_reg   <= top;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                tket_pkg::S_EVICT_CAP:
                begin
                    evicted_valid_reg <= 1'b1;
                end
                tket_pkg::S_SHIFT_WR:
                begin
                    j_reg <= j_minus1;
                end
                tket_pkg::S_WRITE:
                begin
                    inserted_reg <= 1'b1;
                    rank_reg     <= 3'(pos_reg);
                    eval_reg     <= eval_reg + 32'd1;
                    if (!full)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    if (pos_reg == '0)
                    begin
                        best_reg <= item_reg.fitness;
                    end
                end
                tket_pkg::S_READ_CAP:
                begin
                    entry_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers; the entry and tag fields are cleared with the item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg        <= req;
            evicted_tag_reg <= '0;
            entry_reg       <= '0;
        end
        else if (state_reg == tket_pkg::S_EVICT_CAP)
        begin
            evicted_tag_reg <= mem_rd_data.tag;
        end
        else if (state_reg == tket_pkg::S_READ_CAP)
        begin
            entry_reg <= mem_rd_data;
        end
    end

    // The list never grows past its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LIST_DEPTH))
        else $error("entry count above list depth");

    // An eviction is only started on a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tket_pkg::S_EVICT_RD) |-> full)
        else $error("eviction on a list that is not full");

    // A write into a list that is not full grows it by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tket_pkg::S_WRITE && !full)
            |=> count_reg == $past(count_reg + CW'(1)))
        else $error("entry count did not grow on insertion");

    // The generation only moves when an item is dispatched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tket_pkg::S_DISPATCH) |=> $stable(gen_reg))
        else $error("generation changed outside dispatch");

    // The comparator only looks at stored ranks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tket_pkg::S_SCAN_CMP) |-> (idx_reg < count_reg))
        else $error("scan compared beyond the stored entries");

endmodule
`default_nettype wire

// ===== sv/top_k_elite_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_elite_tracker: sorted list of the best scored entries
// Keeps the LIST_DEPTH highest-fitness entries in rank order.
// ----------------------------------------------------------------------------
// Usage: an item on the req channel is either a scored entry to register, a
// new-generation mark, or a read of one rank. Each item gives exactly one
// item on the rsp channel, with the insert or read fields and the current
// list count, best fitness, generation and evaluated count.
// The block works on one item at a time. A new-generation item passes from
// dispatch to done, a read reads and captures its rank, and a register item
// with a payload scans for its place, captures the evicted tag on a full
// list, moves the lower entries down and writes the new entry. The memory
// ports and the single comparator step through the list one rank at a time,
// first to find the place and then to move the lower entries down. The next
// item is taken only once the sequencer is idle again, after the previous
// result has left it.
// req_stall is low only while the sequencer is idle. The output register
// holds a result while rsp_stall is high; the next item may already be
// accepted then, and its result waits until the register is free.
// Reset empties the list, sets the generation to 1 and the evaluated count
// to 0; the entry memory is not cleared, as no read reaches an empty rank.
// ----------------------------------------------------------------------------
module top_k_elite_tracker #(
    parameter int unsigned LIST_DEPTH = tket_pkg::LIST_DEPTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  tket_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output tket_pkg::out_item_t rsp
);

    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    tket_pkg::mem_ctl_t  mem_ctl;
    logic [AW-1:0]       mem_rd_addr;
    logic [AW-1:0]       mem_wr_addr;
    tket_pkg::entry_t    mem_wr_data;
    tket_pkg::entry_t    mem_rd_data;
    logic                res_valid;
    logic                res_take;
    tket_pkg::out_item_t res;

    logic                rsp_valid_reg;
    tket_pkg::out_item_t rsp_reg;

    assign res_take = !rsp_valid_reg || !rsp_stall;

    tket_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

    tket_store #(
        .LIST_DEPTH (LIST_DEPTH),
        .AW         (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
